FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with active-low reset
`define RSP_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define RSP_ASSERT(lbl, prop, msg) \
    `RSP_ASSERT_ON(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: hdl/rsp_pkg.sv
package rsp_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam int unsigned LEN_W       = 11;

    localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] CAPACITY_RST = LEN_W'(1024);
    localparam logic [7:0]       EOF_RST      = 8'hFF;

    localparam logic [7:0] START_MARK = 8'h24;
    localparam logic [7:0] END_MARK   = 8'h23;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_EOF_CODE = 2'd1;

    typedef enum logic [2:0] {
        K_DATA = 3'd0,
        K_GOOD = 3'd1,
        K_BAD  = 3'd2,
        K_OVER = 3'd3,
        K_EOF  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_BODY  = 4'b0010,
        PH_SUMHI = 4'b0100,
        PH_SUMLO = 4'b1000
    } t_phase;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } t_result;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return d;
    endfunction

endpackage

FILE: hdl/rsp_packet_receiver.sv
// Packet deframer for '$' payload '#' hex hex framing. One received byte is
// taken in every clock cycle while o_stall is low; each byte is handled in
// the cycle it is transferred and gives at most one result, which leaves
// through an output register backed by one skid entry. o_stall rises only
// when both are full, so a result waiting downstream does not hold up input
// until a second one is pending. Payload bytes come out as they arrive,
// followed by one status result per packet: good with its length, checksum
// mismatch, overflow past the capacity limit, or abort on the end-of-input byte.
`include "assert_macros.svh"

module rsp_packet_receiver import rsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_rx_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [LEN_W-1:0] o_packet_length,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0] r_capacity;
    logic [7:0]       r_eof_code;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [LEN_W-1:0] r_count, n_count;
    logic [3:0]       r_high, n_high;
    logic             r_out_valid, r_skid_valid;
    t_result          r_out, r_skid;

    logic             in_acc, out_take, res_v;
    t_result          res;
    logic [LEN_W-1:0] limit;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign in_acc      = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;
    assign limit       = (r_capacity > MAX_LEN) ? MAX_LEN : r_capacity;

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_count = r_count;
        n_high  = r_high;
        res_v   = 1'b0;
        res     = '{kind: K_DATA, data: 8'd0, len: '0};
        if (in_acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_eof_code) begin
                        res_v    = 1'b1;
                        res.kind = K_EOF;
                    end else if (i_rx_byte == START_MARK) begin
                        n_phase = PH_BODY;
                        n_sum   = 8'd0;
                        n_count = '0;
                    end
                end
                PH_BODY: begin
                    if (i_rx_byte == r_eof_code) begin
                        n_phase  = PH_HUNT;
                        res_v    = 1'b1;
                        res.kind = K_EOF;
                    end else if (i_rx_byte == END_MARK) begin
                        n_phase = PH_SUMHI;
                    end else if (r_count >= limit) begin
                        n_phase  = PH_HUNT;
                        res_v    = 1'b1;
                        res.kind = K_OVER;
                    end else begin
                        n_sum    = r_sum + i_rx_byte;
                        n_count  = r_count + LEN_W'(1);
                        res_v    = 1'b1;
                        res.data = i_rx_byte;
                    end
                end
                PH_SUMHI: begin
                    n_high  = hex_digit(i_rx_byte);
                    n_phase = PH_SUMLO;
                end
                PH_SUMLO: begin
                    n_phase = PH_HUNT;
                    res_v   = 1'b1;
                    if ({r_high, hex_digit(i_rx_byte)} == r_sum) begin
                        res.kind = K_GOOD;
                        res.len  = r_count;
                    end else begin
                        res.kind = K_BAD;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RST;
            r_eof_code   <= EOF_RST;
            r_phase      <= PH_HUNT;
            r_sum        <= 8'd0;
            r_count      <= '0;
            r_high       <= 4'd0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_CAPACITY) begin
                    r_capacity <= i_cfg_data;
                end else if (i_cfg_index == CFG_EOF_CODE) begin
                    r_eof_code <= i_cfg_data[7:0];
                end
            end
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_high  <= n_high;
            if (r_skid_valid) begin
                if (out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || out_take) begin
                r_out_valid <= res_v;
            end else if (res_v) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload side of the output register and skid entry
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            r_out <= res;
        end else if (res_v) begin
            r_skid <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_payload_byte  = r_out.data;
    assign o_packet_length = r_out.len;

    `RSP_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid full with output empty")
    `RSP_ASSERT(a_count_bound, r_count <= MAX_LEN, "byte count beyond maximum payload")
    `RSP_ASSERT(a_start_opens_body, (in_acc && r_phase == PH_HUNT && i_rx_byte == START_MARK && i_rx_byte != r_eof_code) |=> (r_phase == PH_BODY && r_count == '0), "start mark did not open a packet")
    `RSP_ASSERT(a_good_len_bound, (o_valid && o_kind == K_GOOD) |-> (o_packet_length <= MAX_LEN), "good packet longer than maximum payload")

endmodule
